/* hw/rtl/mcd_pkg.sv */
package mcd_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int DEF_WINDOW     = 7;

  // Field widths.
  localparam int PIX_W      = 8;
  localparam int COL_W      = 11;
  localparam int ROW_W      = 12;
  localparam int VAL_W      = 19;
  localparam int IW_W       = 12;
  localparam int IH_W       = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 19;
  localparam int SQ_W       = 2 * PIX_W;

  // Largest interest value that the result field can carry.
  localparam logic [VAL_W-1:0] VAL_MAX = '1;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 2'd2;

  // Register values after reset.
  localparam logic [VAL_W-1:0] RST_THRESHOLD = 19'd1000;
  localparam logic [IW_W-1:0]  RST_WIDTH     = 12'd640;
  localparam logic [IH_W-1:0]  RST_HEIGHT    = 13'd480;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } pixel_t;

  typedef struct packed {
    logic             centre_valid;
    logic [COL_W-1:0] centre_col;
    logic [ROW_W-1:0] centre_row;
    logic [VAL_W-1:0] interest_value;
    logic             is_corner;
  } result_t;

  typedef struct packed {
    logic [VAL_W-1:0] threshold;
    logic [IW_W-1:0]  width;
    logic [IH_W-1:0]  height;
  } cfg_t;

  // Position of a window centre as it travels down the pipeline.
  typedef struct packed {
    logic             valid;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } meta_t;

endpackage

/* hw/rtl/mcd_ram.sv */
module mcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port; a read in the same cycle as a
  // write to the same address returns the old word.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/mcd_front.sv */
module mcd_front #(
  parameter int MAX_WIDTH  = mcd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = mcd_pkg::DEF_MAX_HEIGHT,
  parameter int WINDOW     = mcd_pkg::DEF_WINDOW
) (
  input  logic                              clk,
  input  logic                              rst,
  input  mcd_pkg::cfg_t                     cfg,
  input  logic                              pixel_valid,
  output logic                              pixel_ready,
  input  mcd_pkg::pixel_t                   pixel_data,
  output logic                              win_valid,
  input  logic                              win_ready,
  output logic [WINDOW*WINDOW*mcd_pkg::PIX_W-1:0] window,
  output mcd_pkg::meta_t                    win_meta
);
  import mcd_pkg::*;

  localparam int LINES  = WINDOW - 1;
  localparam int HALF   = (WINDOW - 1) / 2;
  localparam int OFFSET = WINDOW - 1 - HALF;
  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int LW     = LINES * PIX_W;

  // Raster counters and line-store clearing after reset.
  logic [COL_W-1:0] column_count, column_count_next;
  logic [ROW_W-1:0] row_count, row_count_next;
  logic             clearing;
  logic [AW-1:0]    clr_addr;

  // Stage 1: pixel waiting for its column of the line store.
  logic             v1;
  logic [PIX_W-1:0] s1_pixel;
  logic [AW-1:0]    s1_addr;
  meta_t            s1_meta;
  logic             fwd;
  logic [LW-1:0]    fwd_data;

  // Stage 2: the window itself.
  logic             v2;
  logic [PIX_W-1:0] win [WINDOW][WINDOW];
  meta_t            meta2;

  logic             accept, move1, ready2;
  logic [COL_W-1:0] col_cur;
  logic [ROW_W-1:0] row_cur;
  logic             col_end, row_end;
  meta_t            meta_cur;
  logic [AW-1:0]    rd_addr;
  logic [LW-1:0]    rd_data, col_data, new_col;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [LW-1:0]    wr_data;

  // Handshake along the two stages.
  assign ready2      = !v2 || win_ready;
  assign move1       = v1 && ready2;
  assign pixel_ready = !clearing && (!v1 || ready2);
  assign accept      = pixel_valid && pixel_ready;

  // Position of the incoming pixel and the counters after it.
  always_comb begin
    col_cur = pixel_data.frame_start ? '0 : column_count;
    row_cur = pixel_data.frame_start ? '0 : row_count;
    if (32'(col_cur) >= MAX_WIDTH) begin
      col_cur = '0;
    end
    col_end = ((IW_W'(col_cur) + IW_W'(1)) >= cfg.width) || ((32'(col_cur) + 1) >= MAX_WIDTH);
    row_end = ((IH_W'(row_cur) + IH_W'(1)) >= cfg.height) ||
              ((32'(row_cur) + 1) >= MAX_HEIGHT);
    if (col_end) begin
      column_count_next = '0;
      row_count_next    = row_end ? '0 : row_cur + ROW_W'(1);
    end else begin
      column_count_next = col_cur + COL_W'(1);
      row_count_next    = row_cur;
    end
    meta_cur.valid = (32'(col_cur) >= WINDOW - 1) && (32'(row_cur) >= WINDOW - 1);
    meta_cur.col   = meta_cur.valid ? col_cur - COL_W'(OFFSET) : '0;
    meta_cur.row   = meta_cur.valid ? row_cur - ROW_W'(OFFSET) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // Zero the line store column by column after reset, from column 0 to MAX_WIDTH - 1.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(MAX_WIDTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // The column read is issued as the pixel is taken; when the previous pixel
  // writes the same column at that edge, its word is forwarded instead.
  assign rd_addr  = AW'(col_cur);
  assign col_data = fwd ? fwd_data : rd_data;
  assign new_col  = {s1_pixel, col_data[LW-1:PIX_W]};

  always_comb begin
    if (clearing) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else begin
      wr_en   = move1;
      wr_addr = s1_addr;
      wr_data = new_col;
    end
  end

  mcd_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Stage 1 registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      fwd <= 1'b0;
    end else if (accept) begin
      v1  <= 1'b1;
      fwd <= move1 && (s1_addr == rd_addr);
    end else if (move1) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel <= pixel_data.pixel;
      s1_addr  <= rd_addr;
      s1_meta  <= meta_cur;
      fwd_data <= new_col;
    end
  end

  // Stage 2: shift the window left and load the new column.
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (move1) begin
      v2 <= 1'b1;
    end else if (win_ready) begin
      v2 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < WINDOW; r++) begin
        for (int c = 0; c < WINDOW; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (move1) begin
      for (int r = 0; r < WINDOW; r++) begin
        for (int c = 0; c < WINDOW - 1; c++) begin
          win[r][c] <= win[r][c+1];
        end
      end
      for (int r = 0; r < LINES; r++) begin
        win[r][WINDOW-1] <= col_data[r*PIX_W +: PIX_W];
      end
      win[WINDOW-1][WINDOW-1] <= s1_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (move1) begin
      meta2 <= s1_meta;
    end
  end

  // Flatten the window for the scoring stages.
  for (genvar r = 0; r < WINDOW; r++) begin : g_row
    for (genvar c = 0; c < WINDOW; c++) begin : g_col
      assign window[(r*WINDOW+c)*PIX_W +: PIX_W] = win[r][c];
    end
  end

  assign win_valid = v2;
  assign win_meta  = meta2;

endmodule

/* hw/rtl/mcd_score.sv */
module mcd_score #(
  parameter int WINDOW = mcd_pkg::DEF_WINDOW
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    win_valid,
  output logic                                    win_ready,
  input  logic [WINDOW*WINDOW*mcd_pkg::PIX_W-1:0] window,
  input  mcd_pkg::meta_t                          win_meta,
  input  logic [mcd_pkg::VAL_W-1:0]               threshold,
  output logic                                    result_valid,
  input  logic                                    result_ready,
  output mcd_pkg::result_t                        result
);
  import mcd_pkg::*;

  localparam int HALF  = (WINDOW - 1) / 2;
  localparam int PAIRS = 2 * HALF;
  localparam int SUM_W = $clog2(PAIRS * 65025 + 1);
  localparam int MW    = (SUM_W > VAL_W) ? SUM_W : VAL_W;
  localparam int WW    = WINDOW * WINDOW * PIX_W;

  function automatic logic [PIX_W-1:0] px(logic [WW-1:0] w, int r, int c);
    return w[(r*WINDOW+c)*PIX_W +: PIX_W];
  endfunction

  function automatic logic [SQ_W-1:0] sq_diff(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
    logic [PIX_W-1:0] d;
    d = (a > b) ? a - b : b - a;
    return SQ_W'(d) * SQ_W'(d);
  endfunction

  // Stage A: squared neighbour differences along the four directions.
  logic            va;
  logic [SQ_W-1:0] sq [4][PAIRS];
  logic [SQ_W-1:0] sq_next [4][PAIRS];
  meta_t           meta_a;

  // Stage B: the four directional sums.
  logic            vb;
  logic [MW-1:0]   sums [4];
  logic [MW-1:0]   sums_next [4];
  meta_t           meta_b;

  logic            ready_b, ready_c;
  logic [MW-1:0]   min01, min23, min_all;
  logic [VAL_W-1:0] iv;
  result_t         result_next;

  assign ready_c   = !result_valid || result_ready;
  assign ready_b   = !vb || ready_c;
  assign win_ready = !va || ready_b;

  // Pairs run through the window centre: row, main diagonal, column and
  // anti-diagonal.
  always_comb begin
    for (int j = 0; j < PAIRS; j++) begin
      sq_next[0][j] = sq_diff(px(window, HALF, j), px(window, HALF, j + 1));
      sq_next[1][j] = sq_diff(px(window, j, j), px(window, j + 1, j + 1));
      sq_next[2][j] = sq_diff(px(window, j, HALF), px(window, j + 1, HALF));
      sq_next[3][j] = sq_diff(px(window, j, 2 * HALF - j),
                              px(window, j + 1, 2 * HALF - j - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (win_ready) begin
      va <= win_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (win_valid && win_ready) begin
      sq     <= sq_next;
      meta_a <= win_meta;
    end
  end

  // Sum each direction.
  always_comb begin
    for (int d = 0; d < 4; d++) begin
      sums_next[d] = '0;
      for (int j = 0; j < PAIRS; j++) begin
        sums_next[d] = sums_next[d] + MW'(sq[d][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (ready_b) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (va && ready_b) begin
      sums   <= sums_next;
      meta_b <= meta_a;
    end
  end

  // Least of the four sums, saturated, then the threshold test.
  always_comb begin
    min01   = (sums[1] < sums[0]) ? sums[1] : sums[0];
    min23   = (sums[3] < sums[2]) ? sums[3] : sums[2];
    min_all = (min23 < min01) ? min23 : min01;
    iv      = (min_all > MW'(VAL_MAX)) ? VAL_MAX : VAL_W'(min_all);
    result_next.centre_valid   = meta_b.valid;
    result_next.centre_col     = meta_b.col;
    result_next.centre_row     = meta_b.row;
    result_next.interest_value = meta_b.valid ? iv : '0;
    result_next.is_corner      = meta_b.valid && (iv > threshold);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ready_c) begin
      result_valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (vb && ready_c) begin
      result <= result_next;
    end
  end

endmodule

/* hw/rtl/moravec_corner_detector_core.sv */
// An accepted pixel moves through stage 1, the window, stage A, stage B and the
// result register. Throughput: one pixel per cycle unless result_ready or the
// clearing pass stalls it, set by the line-store read-modify-write of one
// column per pixel, with the newest column word forwarded between pixels.
// Reset (synchronous, rst high) clears counters, window, pipeline; a clearing
// pass zeroes the line store, pixel_ready low; config writes taken throughout.
module moravec_corner_detector_core #(
  parameter int MAX_WIDTH  = mcd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = mcd_pkg::DEF_MAX_HEIGHT,
  parameter int WINDOW     = mcd_pkg::DEF_WINDOW
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            pixel_valid,
  output logic                            pixel_ready,
  input  mcd_pkg::pixel_t                 pixel_data,
  output logic                            result_valid,
  input  logic                            result_ready,
  output mcd_pkg::result_t                result_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mcd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mcd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mcd_pkg::*;

  cfg_t cfg;
  logic win_valid, win_ready;
  logic [WINDOW*WINDOW*PIX_W-1:0] window;
  meta_t win_meta;

  // Configuration registers; an index beyond the list is ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold <= RST_THRESHOLD;
      cfg.width     <= RST_WIDTH;
      cfg.height    <= RST_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_THRESHOLD: cfg.threshold <= cfg_data[VAL_W-1:0];
        CFG_WIDTH:     cfg.width     <= cfg_data[IW_W-1:0];
        CFG_HEIGHT:    cfg.height    <= cfg_data[IH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mcd_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .WINDOW     (WINDOW)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel_data  (pixel_data),
    .win_valid   (win_valid),
    .win_ready   (win_ready),
    .window      (window),
    .win_meta    (win_meta)
  );

  mcd_score #(
    .WINDOW (WINDOW)
  ) u_score (
    .clk          (clk),
    .rst          (rst),
    .win_valid    (win_valid),
    .win_ready    (win_ready),
    .window       (window),
    .win_meta     (win_meta),
    .threshold    (cfg.threshold),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result_data)
  );

endmodule

/* hw/rtl/mcd_checker.sv */
module mcd_checker (
  input logic             clk,
  input logic             rst,
  input logic             pixel_ready,
  input logic             result_valid,
  input logic             result_ready,
  input mcd_pkg::result_t result_data
);
  import mcd_pkg::*;

  // A stalled result stays offered and unchanged.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_data))
    else $error("stalled result changed or dropped");

  // A result outside the borders carries all-zero fields.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_data.centre_valid |-> result_data == '0)
    else $error("invalid centre with nonzero fields");

  // Only a valid centre can be flagged as a corner.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_data.is_corner |-> result_data.centre_valid)
    else $error("corner flagged on an invalid centre");

  // The line store is being cleared right after reset, so no pixel is taken.
  assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !pixel_ready)
    else $error("pixel request taken during the clearing pass");

endmodule

bind moravec_corner_detector_core mcd_checker u_checker (.*);
